>>> rtl/assert_macros.svh
// Assertion macros shared by the parser RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/hcrp_pkg.sv
// Package for the HEVC configuration record parser: phase and kind codes,
// header field numbers, result and group types. No dependencies.
`timescale 1ns / 1ps

package hcrp_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_ARR_TYPE = 3'd1,
    PH_CNT_HI   = 3'd2,
    PH_CNT_LO   = 3'd3,
    PH_LEN_HI   = 3'd4,
    PH_LEN_LO   = 3'd5,
    PH_PAYLOAD  = 3'd6,
    PH_DONE     = 3'd7
  } phase_t;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_FIELD   = 3'd0,
    KIND_TYPE    = 3'd1,
    KIND_COUNT   = 3'd2,
    KIND_LENGTH  = 3'd3,
    KIND_PAYLOAD = 3'd4,
    KIND_OK      = 3'd5,
    KIND_REJECT  = 3'd6,
    KIND_TRUNC   = 3'd7
  } kind_t;

  // Header field numbers
  localparam logic [4:0] FID_VERSION       = 5'd0;
  localparam logic [4:0] FID_PROF_SPACE    = 5'd1;
  localparam logic [4:0] FID_TIER          = 5'd2;
  localparam logic [4:0] FID_PROF_IDC      = 5'd3;
  localparam logic [4:0] FID_COMPAT        = 5'd4;
  localparam logic [4:0] FID_CONSTRAINT    = 5'd5;
  localparam logic [4:0] FID_LEVEL         = 5'd6;
  localparam logic [4:0] FID_SEGMENT       = 5'd7;
  localparam logic [4:0] FID_PARALLEL      = 5'd8;
  localparam logic [4:0] FID_CHROMA        = 5'd9;
  localparam logic [4:0] FID_DEPTH_LUMA    = 5'd10;
  localparam logic [4:0] FID_DEPTH_CHROMA  = 5'd11;
  localparam logic [4:0] FID_FRAME_RATE    = 5'd12;
  localparam logic [4:0] FID_CONST_RATE    = 5'd13;
  localparam logic [4:0] FID_TEMP_LAYERS   = 5'd14;
  localparam logic [4:0] FID_TEMP_NESTED   = 5'd15;
  localparam logic [4:0] FID_LEN_SIZE      = 5'd16;
  localparam logic [4:0] FID_ARRAY_COUNT   = 5'd17;

  // Header byte positions that complete fields
  localparam logic [4:0] POS_VERSION      = 5'd0;
  localparam logic [4:0] POS_PROFILE      = 5'd1;
  localparam logic [4:0] POS_COMPAT       = 5'd5;
  localparam logic [4:0] POS_CONSTRAINT   = 5'd11;
  localparam logic [4:0] POS_LEVEL        = 5'd12;
  localparam logic [4:0] POS_SEGMENT      = 5'd14;
  localparam logic [4:0] POS_PARALLEL     = 5'd15;
  localparam logic [4:0] POS_CHROMA       = 5'd16;
  localparam logic [4:0] POS_DEPTH_LUMA   = 5'd17;
  localparam logic [4:0] POS_DEPTH_CHROMA = 5'd18;
  localparam logic [4:0] POS_FRAME_RATE   = 5'd20;
  localparam logic [4:0] POS_TEMPORAL     = 5'd21;
  localparam logic [4:0] POS_ARRAYS       = 5'd22;
  localparam logic [4:0] POS_MIN_RECORD   = 5'd24;

  localparam logic [7:0] VERSION_ONE = 8'h01;
  localparam int unsigned MAX_RESULTS = 5;

  // One result item, run_last excluded
  typedef struct packed {
    kind_t        kind;
    logic [4:0]   field_id;
    logic [47:0]  value;
    logic [7:0]   array_number;
    logic [15:0]  unit_number;
  } result_t;

  // All results caused by one byte, slot 0 first
  typedef struct packed {
    logic [2:0]                      cnt;
    result_t [MAX_RESULTS-1:0]       res;
  } group_t;

  function automatic result_t mk_result(kind_t kind, logic [4:0] id, logic [47:0] value,
                                        logic [7:0] arr, logic [15:0] unit);
    result_t r;
    r.kind         = kind;
    r.field_id     = id;
    r.value        = value;
    r.array_number = arr;
    r.unit_number  = unit;
    return r;
  endfunction

endpackage

>>> rtl/hcrp_stream_if.sv
// Valid/ready stream interfaces for record bytes and parsed results.
// Standalone; field widths follow the parser's item format.
`timescale 1ns / 1ps

interface hcrp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       record_end;

  modport source (output valid, byte_value, record_end, input ready);
  modport sink   (input valid, byte_value, record_end, output ready);
endinterface

interface hcrp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  result_kind;
  logic [4:0]  field_id;
  logic [47:0] field_value;
  logic [7:0]  array_number;
  logic [15:0] unit_number;
  logic        run_last;

  modport source (output valid, result_kind, field_id, field_value, array_number,
                  unit_number, run_last, input ready);
  modport sink   (input valid, result_kind, field_id, field_value, array_number,
                  unit_number, run_last, output ready);
endinterface

>>> rtl/hcrp_step.sv
// Parser state and per-byte decode: builds the group of results one byte causes.
// Depends on hcrp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcrp_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      byte_value,
  input  logic            record_end,
  output hcrp_pkg::group_t grp
);
  import hcrp_pkg::*;

  // Parser state
  phase_t      phase, phase_next;
  logic [4:0]  header_position, header_position_next;
  logic [47:0] field_accumulator, field_accumulator_next;
  logic [7:0]  arrays_left, arrays_left_next;
  logic [7:0]  array_counter, array_counter_next;
  logic [15:0] units_left, units_left_next;
  logic [15:0] unit_counter, unit_counter_next;
  logic [15:0] payload_left, payload_left_next;
  logic        record_bad, record_bad_next;

  logic [47:0] acc_shift;
  logic [47:0] byte_ext;
  logic [15:0] len_word;
  logic [7:0]  arrays_dec;
  logic [15:0] units_dec;
  logic [15:0] payload_dec;
  logic        fin_unit, fin_array;
  logic [2:0]  main_cnt;
  kind_t       status;

  assign acc_shift   = {field_accumulator[39:0], byte_value};
  assign byte_ext    = {40'd0, byte_value};
  assign len_word    = {field_accumulator[7:0], byte_value};
  assign arrays_dec  = arrays_left - 8'd1;
  assign units_dec   = units_left - 16'd1;
  assign payload_dec = payload_left - 16'd1;

  // Next state and results for the current byte
  always_comb begin
    phase_next             = phase;
    header_position_next   = (header_position < POS_MIN_RECORD) ?
                             header_position + 5'd1 : header_position;
    field_accumulator_next = field_accumulator;
    arrays_left_next       = arrays_left;
    array_counter_next     = array_counter;
    units_left_next        = units_left;
    unit_counter_next      = unit_counter;
    payload_left_next      = payload_left;
    record_bad_next        = record_bad;
    fin_unit               = 1'b0;
    fin_array              = 1'b0;
    main_cnt               = 3'd0;
    status                 = KIND_OK;
    grp                    = '0;

    unique case (phase)
      PH_HEADER: begin
        field_accumulator_next = acc_shift;
        case (header_position)
          POS_VERSION: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_VERSION, byte_ext, 8'd0, 16'd0);
            main_cnt = 3'd1;
            record_bad_next = (byte_value != VERSION_ONE);
            field_accumulator_next = '0;
          end
          POS_PROFILE: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_PROF_SPACE, {46'd0, byte_value[7:6]},
                                   8'd0, 16'd0);
            grp.res[1] = mk_result(KIND_FIELD, FID_TIER, {47'd0, byte_value[5]}, 8'd0, 16'd0);
            grp.res[2] = mk_result(KIND_FIELD, FID_PROF_IDC, {43'd0, byte_value[4:0]},
                                   8'd0, 16'd0);
            main_cnt = 3'd3;
            field_accumulator_next = '0;
          end
          POS_COMPAT: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_COMPAT, {16'd0, acc_shift[31:0]},
                                   8'd0, 16'd0);
            main_cnt = 3'd1;
            field_accumulator_next = '0;
          end
          POS_CONSTRAINT: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_CONSTRAINT, acc_shift, 8'd0, 16'd0);
            main_cnt = 3'd1;
            field_accumulator_next = '0;
          end
          POS_LEVEL: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_LEVEL, byte_ext, 8'd0, 16'd0);
            main_cnt = 3'd1;
            field_accumulator_next = '0;
          end
          POS_SEGMENT: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_SEGMENT, {32'd0, acc_shift[15:0]},
                                   8'd0, 16'd0);
            main_cnt = 3'd1;
            field_accumulator_next = '0;
          end
          POS_PARALLEL: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_PARALLEL, byte_ext, 8'd0, 16'd0);
            main_cnt = 3'd1;
            field_accumulator_next = '0;
          end
          POS_CHROMA: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_CHROMA, byte_ext, 8'd0, 16'd0);
            main_cnt = 3'd1;
            field_accumulator_next = '0;
          end
          POS_DEPTH_LUMA: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_DEPTH_LUMA, byte_ext, 8'd0, 16'd0);
            main_cnt = 3'd1;
            field_accumulator_next = '0;
          end
          POS_DEPTH_CHROMA: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_DEPTH_CHROMA, byte_ext, 8'd0, 16'd0);
            main_cnt = 3'd1;
            field_accumulator_next = '0;
          end
          POS_FRAME_RATE: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_FRAME_RATE, {32'd0, acc_shift[15:0]},
                                   8'd0, 16'd0);
            main_cnt = 3'd1;
            field_accumulator_next = '0;
          end
          POS_TEMPORAL: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_CONST_RATE, {46'd0, byte_value[7:6]},
                                   8'd0, 16'd0);
            grp.res[1] = mk_result(KIND_FIELD, FID_TEMP_LAYERS, {45'd0, byte_value[5:3]},
                                   8'd0, 16'd0);
            grp.res[2] = mk_result(KIND_FIELD, FID_TEMP_NESTED, {47'd0, byte_value[2]},
                                   8'd0, 16'd0);
            grp.res[3] = mk_result(KIND_FIELD, FID_LEN_SIZE, {46'd0, byte_value[1:0]},
                                   8'd0, 16'd0);
            main_cnt = 3'd4;
            field_accumulator_next = '0;
          end
          POS_ARRAYS: begin
            grp.res[0] = mk_result(KIND_FIELD, FID_ARRAY_COUNT, byte_ext, 8'd0, 16'd0);
            main_cnt = 3'd1;
            arrays_left_next = byte_value;
            phase_next = (record_bad || byte_value == 8'd0) ? PH_DONE : PH_ARR_TYPE;
            field_accumulator_next = '0;
          end
          default: ;
        endcase
      end
      PH_ARR_TYPE: begin
        field_accumulator_next = byte_ext;
        phase_next = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        field_accumulator_next = acc_shift;
        phase_next = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        grp.res[0] = mk_result(KIND_TYPE, 5'd0, {40'd0, acc_shift[23:16]},
                               array_counter, 16'd0);
        grp.res[1] = mk_result(KIND_COUNT, 5'd0, {32'd0, acc_shift[15:0]},
                               array_counter, 16'd0);
        main_cnt = 3'd2;
        units_left_next = acc_shift[15:0];
        unit_counter_next = '0;
        field_accumulator_next = '0;
        if (acc_shift[15:0] == 16'd0) begin
          fin_array = 1'b1;
        end else begin
          phase_next = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        field_accumulator_next = byte_ext;
        phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        grp.res[0] = mk_result(KIND_LENGTH, 5'd0, {32'd0, len_word}, array_counter,
                               unit_counter);
        main_cnt = 3'd1;
        payload_left_next = len_word;
        field_accumulator_next = '0;
        if (len_word == 16'd0) begin
          fin_unit = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        grp.res[0] = mk_result(KIND_PAYLOAD, 5'd0, byte_ext, array_counter, unit_counter);
        main_cnt = 3'd1;
        payload_left_next = payload_dec;
        if (payload_dec == 16'd0) begin
          fin_unit = 1'b1;
        end
      end
      PH_DONE: ;
      default: ;
    endcase

    // End of a NAL unit
    if (fin_unit) begin
      unit_counter_next = unit_counter + 16'd1;
      units_left_next = units_dec;
      if (units_dec == 16'd0) begin
        fin_array = 1'b1;
      end else begin
        phase_next = PH_LEN_HI;
      end
    end

    // End of an array
    if (fin_array) begin
      array_counter_next = array_counter + 8'd1;
      arrays_left_next = arrays_dec;
      unit_counter_next = '0;
      phase_next = (arrays_dec == 8'd0) ? PH_DONE : PH_ARR_TYPE;
    end

    grp.cnt = main_cnt;

    // Record end: append status, return to the start state
    if (record_end) begin
      if (record_bad_next || header_position_next < POS_MIN_RECORD) begin
        status = KIND_REJECT;
      end else if (phase_next == PH_PAYLOAD && payload_left_next != 16'd0) begin
        status = KIND_TRUNC;
      end
      grp.res[main_cnt] = mk_result(status, 5'd0, 48'd0, 8'd0, 16'd0);
      grp.cnt = main_cnt + 3'd1;
      phase_next             = PH_HEADER;
      header_position_next   = '0;
      field_accumulator_next = '0;
      arrays_left_next       = '0;
      array_counter_next     = '0;
      units_left_next        = '0;
      unit_counter_next      = '0;
      payload_left_next      = '0;
      record_bad_next        = 1'b0;
    end
  end

  // State registers, updated on each byte transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_position   <= '0;
      field_accumulator <= '0;
      arrays_left       <= '0;
      array_counter     <= '0;
      units_left        <= '0;
      unit_counter      <= '0;
      payload_left      <= '0;
      record_bad        <= 1'b0;
    end else if (accept) begin
      phase             <= phase_next;
      header_position   <= header_position_next;
      field_accumulator <= field_accumulator_next;
      arrays_left       <= arrays_left_next;
      array_counter     <= array_counter_next;
      units_left        <= units_left_next;
      unit_counter      <= unit_counter_next;
      payload_left      <= payload_left_next;
      record_bad        <= record_bad_next;
    end
  end

  `ASSERT_NEXT(a_end_restarts, clk, rst, accept && record_end, phase == PH_HEADER && header_position == 5'd0, "record end did not return parser to start")
  `ASSERT_IMPLIES(a_pos_sat, clk, rst, 1'b1, header_position <= POS_MIN_RECORD, "header position past saturation")
  `ASSERT_IMPLIES(a_payload_live, clk, rst, phase == PH_PAYLOAD, payload_left != 16'd0, "payload phase with nothing left")

endmodule

>>> rtl/hcrp_serializer.sv
// Result group buffer and output register: hands out a byte's results one per transfer.
// Depends on hcrp_pkg, hcrp_stream_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hcrp_serializer (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  hcrp_pkg::group_t grp_in,
  output logic             free,
  hcrp_result_if.source    results
);
  import hcrp_pkg::*;

  // Pending results of the last byte and the output register
  result_t [MAX_RESULTS-1:0] pend, pend_next;
  logic [2:0]                cnt, cnt_next;
  result_t                   res_q;
  logic                      res_last;
  logic                      res_valid, res_valid_next;
  logic                      move;
  logic                      fire;

  assign fire = res_valid && results.ready;
  assign move = (cnt != 3'd0) && (!res_valid || results.ready);
  assign free = (cnt == 3'd0) || (cnt == 3'd1 && move);

  // Buffer next state: shift on move, replace on load
  always_comb begin
    pend_next      = pend;
    cnt_next       = cnt;
    res_valid_next = res_valid;
    if (move) begin
      pend_next = {result_t'('0), pend[MAX_RESULTS-1:1]};
      cnt_next = cnt - 3'd1;
      res_valid_next = 1'b1;
    end else if (fire) begin
      res_valid_next = 1'b0;
    end
    if (load) begin
      pend_next = grp_in.res;
      cnt_next = grp_in.cnt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      res_valid <= res_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend <= pend_next;
    if (move) begin
      res_q    <= pend[0];
      res_last <= (cnt == 3'd1);
    end
  end

  assign results.valid        = res_valid;
  assign results.result_kind  = res_q.kind;
  assign results.field_id     = res_q.field_id;
  assign results.field_value  = res_q.value;
  assign results.array_number = res_q.array_number;
  assign results.unit_number  = res_q.unit_number;
  assign results.run_last     = res_last;

  `ASSERT_IMPLIES(a_cnt_range, clk, rst, 1'b1, cnt <= 3'd5, "result buffer count out of range")
  `ASSERT_IMPLIES(a_load_free, clk, rst, load, cnt <= 3'd1, "group loaded over pending results")
  `ASSERT_NEXT(a_move_fills, clk, rst, move, res_valid, "moved result not presented")
  `ASSERT_NEXT(a_load_cnt, clk, rst, load, cnt == $past(grp_in.cnt), "loaded group count lost")

endmodule

>>> rtl/hevc_config_record_parser_top.sv
// Channel     Dir  Payload                                      Transfer
// bytes       in   byte_value[7:0], record_end                  valid && ready
// results     out  result_kind, field_id, field_value[47:0],    valid && ready
//                  array_number, unit_number, run_last
//
// A byte's results (0 to 5 of them) are buffered, and the byte channel takes the
// next byte once the buffer is empty or in the cycle that the last pending result moves
// to the output register. Results leave one per cycle while results are pending and
// results.ready is high; a transferred byte's results are loaded into the buffer and
// then move to the output register when it is free. Reset (rst, synchronous) clears
// parser state and empties the buffer; a stall on results back-pressures bytes while results are pending.
//
// Top level of the HEVC configuration record parser.
// Depends on hcrp_pkg, hcrp_stream_if, hcrp_step and hcrp_serializer.
`timescale 1ns / 1ps

module hevc_config_record_parser_top (
  input  logic          clk,
  input  logic          rst,
  hcrp_byte_if.sink     bytes,
  hcrp_result_if.source results
);
  import hcrp_pkg::*;

  group_t grp;
  logic   free;
  logic   accept;

  // Byte transfer
  assign bytes.ready = free;
  assign accept      = bytes.valid && free;

  hcrp_step u_step (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .byte_value (bytes.byte_value),
    .record_end (bytes.record_end),
    .grp        (grp)
  );

  hcrp_serializer u_ser (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .grp_in  (grp),
    .free    (free),
    .results (results)
  );

endmodule

>>> tb/hevc_config_record_parser_top_tb.sv
// Self-checking testbench for hevc_config_record_parser_top: directed records, then
// random records under varying valid/ready idling, checked against a predictor.
// Depends on hcrp_pkg, hcrp_stream_if and the parser RTL.
`timescale 1ns / 1ps

module hevc_config_record_parser_top_tb;
  import hcrp_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned HOLD_CYCLES   = 250;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned BYTES_PER_MIX = 110;
  localparam logic [4:0]  NO_FIELD      = 5'd0;

  // Expected result, run_last included
  typedef struct packed {
    kind_t        kind;
    logic [4:0]   id;
    logic [47:0]  value;
    logic [7:0]   arr;
    logic [15:0]  unit;
    logic         last;
  } parsed_result_t;

  // Directed stimulus row; status is used on the final byte of a record only
  typedef struct packed {
    logic [7:0] b;
    logic       e;
    kind_t      status;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 32;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // one-byte record right after reset: version 0, too short
    '{8'h00, 1'b1, KIND_REJECT},
    // header: version 1, then bit-split and multi-byte fields at extremes
    '{8'h01, 1'b0, KIND_OK}, '{8'hFF, 1'b0, KIND_OK},
    '{8'hFF, 1'b0, KIND_OK}, '{8'h00, 1'b0, KIND_OK}, '{8'hFF, 1'b0, KIND_OK},
    '{8'h00, 1'b0, KIND_OK},
    '{8'h80, 1'b0, KIND_OK}, '{8'h7F, 1'b0, KIND_OK}, '{8'h01, 1'b0, KIND_OK},
    '{8'hFE, 1'b0, KIND_OK}, '{8'hAA, 1'b0, KIND_OK}, '{8'h55, 1'b0, KIND_OK},
    '{8'hFF, 1'b0, KIND_OK},
    '{8'hF0, 1'b0, KIND_OK}, '{8'h0F, 1'b0, KIND_OK},
    '{8'h00, 1'b0, KIND_OK}, '{8'hFF, 1'b0, KIND_OK}, '{8'h00, 1'b0, KIND_OK},
    '{8'hFF, 1'b0, KIND_OK},
    '{8'h12, 1'b0, KIND_OK}, '{8'h34, 1'b0, KIND_OK},
    '{8'hFF, 1'b0, KIND_OK},
    '{8'h01, 1'b0, KIND_OK},
    // one array of two NALs: zero-length NAL, then max length cut short
    '{8'hFF, 1'b0, KIND_OK}, '{8'h00, 1'b0, KIND_OK}, '{8'h02, 1'b0, KIND_OK},
    '{8'h00, 1'b0, KIND_OK}, '{8'h00, 1'b0, KIND_OK},
    '{8'hFF, 1'b0, KIND_OK}, '{8'hFF, 1'b0, KIND_OK},
    '{8'h5A, 1'b1, KIND_TRUNC}
  };

  logic clk = 1'b0;
  logic rst;

  hcrp_byte_if   bytes_ch ();
  hcrp_result_if results_ch ();

  hevc_config_record_parser_top dut (
    .clk     (clk),
    .rst     (rst),
    .bytes   (bytes_ch),
    .results (results_ch)
  );

  always #4 clk = ~clk;

  // Predictor state
  phase_t      phase;
  logic [4:0]  hdr_pos;
  logic [47:0] acc;
  logic [7:0]  arrays_left;
  logic [7:0]  array_idx;
  logic [15:0] units_left;
  logic [15:0] unit_idx;
  logic [15:0] payload_left;
  logic        bad;

  parsed_result_t expected_results[$];
  parsed_result_t step_results[$];

  int unsigned parsed_bytes, results_checked, mismatches;
  int unsigned records, records_ok, records_rejected, records_truncated;
  int unsigned src_idle_pct, sink_idle_pct;
  int unsigned hold_requests, hold_served, hold_left;
  int unsigned cycles;

  function automatic void clear_parse_state();
    phase        = PH_HEADER;
    hdr_pos      = '0;
    acc          = '0;
    arrays_left  = '0;
    array_idx    = '0;
    units_left   = '0;
    unit_idx     = '0;
    payload_left = '0;
    bad          = 1'b0;
  endfunction

  function automatic void note(kind_t k, logic [4:0] id, logic [47:0] v,
                               logic [7:0] arr, logic [15:0] unit);
    parsed_result_t r;
    if (step_results.size() >= MAX_RESULTS) return;
    r.kind  = k;
    r.id    = id;
    r.value = v;
    r.arr   = arr;
    r.unit  = unit;
    r.last  = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void field(logic [4:0] id, logic [47:0] v);
    note(KIND_FIELD, id, v, 8'd0, 16'd0);
  endfunction

  function automatic void end_array();
    array_idx++;
    arrays_left--;
    unit_idx = '0;
    phase    = (arrays_left == 0) ? PH_DONE : PH_ARR_TYPE;
  endfunction

  function automatic void end_unit();
    unit_idx++;
    units_left--;
    if (units_left == 0) end_array();
    else phase = PH_LEN_HI;
  endfunction

  // Advance the predictor by one accepted byte and queue the results it causes
  function automatic void parse_byte(logic [7:0] b, logic e);
    logic [4:0] pos;
    logic       emitted;
    kind_t      status;
    pos = hdr_pos;
    step_results.delete();
    if (phase != PH_DONE || e) parsed_bytes++;
    if (hdr_pos < POS_MIN_RECORD) hdr_pos++;

    case (phase)
      PH_HEADER: begin
        acc     = {acc[39:0], b};
        emitted = 1'b1;
        case (pos)
          POS_VERSION: begin
            field(FID_VERSION, 48'(b));
            bad = (b != VERSION_ONE);
          end
          POS_PROFILE: begin
            field(FID_PROF_SPACE, 48'(b[7:6]));
            field(FID_TIER, 48'(b[5]));
            field(FID_PROF_IDC, 48'(b[4:0]));
          end
          POS_COMPAT:       field(FID_COMPAT, 48'(acc[31:0]));
          POS_CONSTRAINT:   field(FID_CONSTRAINT, acc);
          POS_LEVEL:        field(FID_LEVEL, 48'(b));
          POS_SEGMENT:      field(FID_SEGMENT, 48'(acc[15:0]));
          POS_PARALLEL:     field(FID_PARALLEL, 48'(b));
          POS_CHROMA:       field(FID_CHROMA, 48'(b));
          POS_DEPTH_LUMA:   field(FID_DEPTH_LUMA, 48'(b));
          POS_DEPTH_CHROMA: field(FID_DEPTH_CHROMA, 48'(b));
          POS_FRAME_RATE:   field(FID_FRAME_RATE, 48'(acc[15:0]));
          POS_TEMPORAL: begin
            field(FID_CONST_RATE, 48'(b[7:6]));
            field(FID_TEMP_LAYERS, 48'(b[5:3]));
            field(FID_TEMP_NESTED, 48'(b[2]));
            field(FID_LEN_SIZE, 48'(b[1:0]));
          end
          POS_ARRAYS: begin
            field(FID_ARRAY_COUNT, 48'(b));
            arrays_left = b;
            phase = (bad || b == 0) ? PH_DONE : PH_ARR_TYPE;
          end
          default: emitted = 1'b0;
        endcase
        // multi-byte fields keep collecting until their last byte
        if (emitted) acc = '0;
      end
      PH_ARR_TYPE: begin
        acc   = {40'd0, b};
        phase = PH_CNT_HI;
      end
      PH_CNT_HI: begin
        acc   = {acc[39:0], b};
        phase = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        acc = {acc[39:0], b};
        note(KIND_TYPE, NO_FIELD, 48'(acc[23:16]), array_idx, 16'd0);
        units_left = acc[15:0];
        note(KIND_COUNT, NO_FIELD, 48'(units_left), array_idx, 16'd0);
        unit_idx = '0;
        acc      = '0;
        if (units_left == 0) end_array();
        else phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        acc   = {40'd0, b};
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        payload_left = {acc[7:0], b};
        acc = '0;
        note(KIND_LENGTH, NO_FIELD, 48'(payload_left), array_idx, unit_idx);
        if (payload_left == 0) end_unit();
        else phase = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        note(KIND_PAYLOAD, NO_FIELD, 48'(b), array_idx, unit_idx);
        payload_left--;
        if (payload_left == 0) end_unit();
      end
      default: ;  // trailing bytes after the last array
    endcase

    // record end: status, then back to a fresh record
    if (e) begin
      if (bad || hdr_pos < POS_MIN_RECORD) status = KIND_REJECT;
      else if (phase == PH_PAYLOAD && payload_left != 0) status = KIND_TRUNC;
      else status = KIND_OK;
      note(status, NO_FIELD, 48'd0, 8'd0, 16'd0);
      records++;
      case (status)
        KIND_REJECT: records_rejected++;
        KIND_TRUNC:  records_truncated++;
        default:     records_ok++;
      endcase
      clear_parse_state();
    end

    foreach (step_results[i]) begin
      parsed_result_t r;
      r = step_results[i];
      r.last = (i == step_results.size() - 1);
      expected_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [47:0] got, logic [47:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s = 0x%0h, expected 0x%0h",
                                results_checked, name, got, want));
  endtask

  // Offer one byte, with random idle cycles first; returns at the transfer edge
  task automatic send_byte(logic [7:0] b, logic e);
    while ($urandom_range(99) < src_idle_pct) begin
      bytes_ch.valid <= 1'b0;
      @(posedge clk);
    end
    bytes_ch.valid      <= 1'b1;
    bytes_ch.byte_value <= b;
    bytes_ch.record_end <= e;
    do @(posedge clk); while (bytes_ch.ready !== 1'b1);
    parse_byte(b, e);
  endtask

  // Result sink: random ready, one long hold on request, in-order checking
  always @(posedge clk) begin
    parsed_result_t want;
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      if (results_ch.valid === 1'b1 && results_ch.ready === 1'b1) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with nothing expected",
                                    results_ch.result_kind));
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 48'(results_ch.result_kind), 48'(want.kind));
          check_field("field_id", 48'(results_ch.field_id), 48'(want.id));
          check_field("field_value", results_ch.field_value, want.value);
          check_field("array_number", 48'(results_ch.array_number), 48'(want.arr));
          check_field("unit_number", 48'(results_ch.unit_number), 48'(want.unit));
          check_field("run_last", 48'(results_ch.run_last), 48'(want.last));
        end
        results_checked++;
      end
      if (hold_requests != hold_served) begin
        hold_served      <= hold_requests;
        hold_left        <= HOLD_CYCLES;
        results_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left        <= hold_left - 1;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] rec_bytes[$];
    logic [7:0] v;
    dir_row_t   row;
    parsed_result_t r;
    int unsigned shape, len, n_arrays, n_units, pick, cut, target, mix;

    rst                 <= 1'b1;
    bytes_ch.valid      <= 1'b0;
    bytes_ch.byte_value <= 8'd0;
    bytes_ch.record_end <= 1'b0;
    hold_requests = 0;
    src_idle_pct  = 13;
    sink_idle_pct = 61;
    clear_parse_state();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed records; the final status of each is taken from the table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIRECTED[i];
      send_byte(row.b, row.e);
      if (row.e) begin
        r = expected_results.pop_back();
        r.kind = row.status;
        expected_results.push_back(r);
      end
    end

    // Random records in three idling mixes; the last one opens with a long stall
    for (mix = 0; mix < 3; mix++) begin
      src_idle_pct  = (mix == 0) ? 13 : (mix == 1) ? 61 : 0;
      sink_idle_pct = (mix == 0) ? 61 : (mix == 1) ? 13 : 0;
      if (mix == 2) hold_requests <= hold_requests + 1;
      target = parsed_bytes + BYTES_PER_MIX;
      while (parsed_bytes < target) begin
        rec_bytes.delete();
        shape = $urandom_range(99);
        if (shape >= 88) begin
          // noise: random bytes, half of them with a valid version
          len = $urandom_range(40, 1);
          repeat (len) rec_bytes.push_back(8'($urandom_range(255)));
          if (shape >= 94) rec_bytes[0] = VERSION_ONE;
        end else begin
          // well-formed record; bad version or cut short for some shapes
          v = 8'($urandom_range(255));
          if (v == VERSION_ONE) v = 8'h00;
          rec_bytes.push_back((shape >= 80) ? v : VERSION_ONE);
          repeat (21) rec_bytes.push_back(8'($urandom_range(255)));
          n_arrays = ($urandom_range(9) == 0) ? 0 : $urandom_range(2, 1);
          rec_bytes.push_back(8'(n_arrays));
          repeat (n_arrays) begin
            rec_bytes.push_back(8'($urandom_range(255)));
            n_units = ($urandom_range(6) == 0) ? 0 : $urandom_range(2, 1);
            rec_bytes.push_back(8'd0);
            rec_bytes.push_back(8'(n_units));
            repeat (n_units) begin
              pick = $urandom_range(99);
              len  = (pick < 15) ? 0 : (pick < 85) ? $urandom_range(6, 1)
                                                   : $urandom_range(40, 7);
              rec_bytes.push_back(8'(len >> 8));
              rec_bytes.push_back(8'(len));
              repeat (len) rec_bytes.push_back(8'($urandom_range(255)));
            end
          end
          if ($urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) rec_bytes.push_back(8'($urandom_range(255)));
          if (shape >= 70 && shape < 80) begin
            cut = $urandom_range(rec_bytes.size(), 1);
            while (rec_bytes.size() > cut) void'(rec_bytes.pop_back());
          end
        end
        foreach (rec_bytes[i]) send_byte(rec_bytes[i], i == rec_bytes.size() - 1);
      end
    end
    bytes_ch.valid <= 1'b0;

    // Drain, then keep watching for stray results
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d records (%0d ok, %0d rejected, %0d truncated), %0d bytes parsed",
             records, records_ok, records_rejected, records_truncated, parsed_bytes);
    $display("%0d results checked under three idling mixes and a %0d-cycle output stall",
             results_checked, HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
